### sv/svg_pkg.sv
// ----------------------------------------------------------------------------
// svg_pkg
// Shared types, constants and rounding helpers of the one-qubit gate engine.
// ----------------------------------------------------------------------------
package svg_pkg;

    // Default number of qubits the store is sized for.
    localparam int MAX_QUBITS_DEF = 10;

    // Fixed field widths.
    localparam int FUNC_W    = 2;
    localparam int INDEX_W   = 10;
    localparam int AMP_W     = 16;
    localparam int WORD_W    = 32;
    localparam int NORM_W    = 40;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int SCALE_W   = 24;
    localparam int QCNT_W    = 4;

    // Item functions.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_PROBE = 2'd2,
        FUNC_APPLY = 2'd3
    } t_func;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COEF_00 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_01 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_10 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_11 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_QUBITS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 3'd6;

    // Reset values of the registers.
    localparam logic [WORD_W-1:0]  COEF_ONE    = 32'h4000_0000;
    localparam logic [WORD_W-1:0]  COEF_ZERO   = 32'h0000_0000;
    localparam logic [QCNT_W-1:0]  QUBITS_RST  = 4'd10;
    localparam logic [SCALE_W-1:0] SCALE_RST   = 24'h01_0000;

    localparam logic [NORM_W-1:0]  NORM_MAX    = {NORM_W{1'b1}};

    // Round a Q5.28 sum to Q1.14 (add half, floor) and saturate to 16 bits.
    function automatic logic [AMP_W-1:0] rnd14(input logic signed [33:0] x);
        logic signed [34:0] t;
        logic signed [20:0] q;
        t = $signed({x[33], x}) + 35'sd8192;
        q = t[34:14];
        if (q > 21'sd32767) begin
            rnd14 = 16'h7FFF;
        end else if (q < -21'sd32768) begin
            rnd14 = 16'h8000;
        end else begin
            rnd14 = q[15:0];
        end
    endfunction

    // Round a scaled part by 2^16 (add half, floor) and saturate to 16 bits.
    function automatic logic [AMP_W-1:0] rnd16(input logic signed [40:0] x);
        logic signed [41:0] t;
        logic signed [25:0] q;
        t = $signed({x[40], x}) + 42'sd32768;
        q = t[41:16];
        if (q > 26'sd32767) begin
            rnd16 = 16'h7FFF;
        end else if (q < -26'sd32768) begin
            rnd16 = 16'h8000;
        end else begin
            rnd16 = q[15:0];
        end
    endfunction

endpackage

### sv/svg_req_if.sv
// ----------------------------------------------------------------------------
// svg_req_if
// Request channel: one item carries a function, an index and an amplitude.
// ----------------------------------------------------------------------------
interface svg_req_if;
    logic                             valid;
    logic                             ready;
    logic [svg_pkg::FUNC_W-1:0]       func;
    logic [svg_pkg::INDEX_W-1:0]      index;
    logic signed [svg_pkg::AMP_W-1:0] amp_re;
    logic signed [svg_pkg::AMP_W-1:0] amp_im;

    modport source (output valid, func, index, amp_re, amp_im, input ready);
    modport sink   (input valid, func, index, amp_re, amp_im, output ready);
endinterface

### sv/svg_rsp_if.sv
// ----------------------------------------------------------------------------
// svg_rsp_if
// Response channel: one item per request with amplitude, norm and error.
// ----------------------------------------------------------------------------
interface svg_rsp_if;
    logic                             valid;
    logic                             ready;
    logic signed [svg_pkg::AMP_W-1:0] out_re;
    logic signed [svg_pkg::AMP_W-1:0] out_im;
    logic [svg_pkg::NORM_W-1:0]       norm_sum;
    logic                             error;

    modport source (output valid, out_re, out_im, norm_sum, error, input ready);
    modport sink   (input valid, out_re, out_im, norm_sum, error, output ready);
endinterface

### sv/svg_cfg_if.sv
// ----------------------------------------------------------------------------
// svg_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface svg_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [svg_pkg::CFG_IDX_W-1:0]  idx;
    logic [svg_pkg::CFG_DAT_W-1:0]  data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

### sv/svg_ram.sv
// ----------------------------------------------------------------------------
// svg_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module svg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/state_vector_one_qubit_gate.sv
// ----------------------------------------------------------------------------
// state_vector_one_qubit_gate
// State vector store with a one-qubit 2x2 complex operator: load, read back,
// probe the norm of the transformed state, or apply the operator in place.
// ----------------------------------------------------------------------------
//  channel | dir | port   | payload
//  --------+-----+--------+------------------------------------------
//  request | in  | i_req  | func, index, amp_re, amp_im
//  result  | out | o_rsp  | out_re, out_im, norm_sum, error
//  config  | in  | i_cfg  | idx, data (always ready)
//
// Write stores the amplitude and read fetches it into the result register.
// Probe and apply work one amplitude pair at a time through the single
// RAM read/write port pair and the shared complex multiply unit; with n
// qubits that is 2^(n-1) pairs. A bad target skips the pass with an error.
// Synchronous active-low reset; the store is not cleared. A new item is
// accepted while an earlier result still waits on a stalled result channel.
// ----------------------------------------------------------------------------
module state_vector_one_qubit_gate #(
    parameter int MAX_QUBITS = svg_pkg::MAX_QUBITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    svg_req_if.sink   i_req,
    svg_rsp_if.source o_rsp,
    svg_cfg_if.sink   i_cfg
);

    localparam int AW    = MAX_QUBITS;
    localparam int DEPTH = 2 ** MAX_QUBITS;
    localparam int CW    = AW + 1;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_RDOUT = 11'b000_0000_0010,
        ST_RDI   = 11'b000_0000_0100,
        ST_RDJ   = 11'b000_0000_1000,
        ST_CAPJ  = 11'b000_0001_0000,
        ST_MUL   = 11'b000_0010_0000,
        ST_SUM   = 11'b000_0100_0000,
        ST_POST  = 11'b000_1000_0000,
        ST_SCL   = 11'b001_0000_0000,
        ST_WR    = 11'b010_0000_0000,
        ST_DONE  = 11'b100_0000_0000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [31:0]                       r_c00, r_c01, r_c10, r_c11;
    logic [svg_pkg::QCNT_W-1:0]        r_tq, r_qiu;
    logic [svg_pkg::SCALE_W-1:0]       r_scale;

    // Item context.
    logic [svg_pkg::FUNC_W-1:0]        r_func;
    logic                              r_err;
    logic [AW-1:0]                     r_p;
    logic                              r_k;
    logic                              r_wj;
    logic [31:0]                       r_s0, r_s1, r_a0, r_a1, r_rd;
    logic signed [31:0]                r_pr [4];
    logic signed [31:0]                r_pi [4];
    logic [15:0]                       r_re, r_im;
    logic signed [40:0]                r_sre, r_sim;
    logic [svg_pkg::NORM_W-1:0]        r_acc;

    // Result register.
    logic                              r_ov;
    logic [15:0]                       r_ore, r_oim;
    logic [svg_pkg::NORM_W-1:0]        r_onorm;
    logic                              r_oerr;

    // RAM port signals.
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [31:0]       ram_wdata, ram_rdata;

    svg_ram #(.WIDTH(svg_pkg::WORD_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Effective qubit count, target check and pair addressing.
    logic [5:0]                 n_eff;
    logic                       bad_tgt;
    logic [AW-1:0]              stride, lo_mask, addr_i, addr_j, in_addr;
    logic [CW-1:0]              pairs;
    logic                       last_pair;
    logic [AW+svg_pkg::INDEX_W-1:0] idx_ext;

    always_comb begin
        if ({2'b00, r_qiu} > 6'(MAX_QUBITS)) begin
            n_eff = 6'(MAX_QUBITS);
        end else begin
            n_eff = {2'b00, r_qiu};
        end
        bad_tgt   = {2'b00, r_tq} >= n_eff;
        stride    = AW'(1) << r_tq;
        lo_mask   = stride - AW'(1);
        addr_i    = (r_p & lo_mask) | ((r_p & ~lo_mask) << 1);
        addr_j    = addr_i | stride;
        pairs     = (CW'(1) << n_eff) >> 1;
        last_pair = ({1'b0, r_p} + CW'(1)) == pairs;
        idx_ext   = {{AW{1'b0}}, i_req.index};
        in_addr   = idx_ext[AW-1:0];
    end

    // Operands of the shared complex multiply-accumulate.
    logic signed [15:0] ar, ai, br, bi, xr, xi, yr, yi;
    always_comb begin
        ar = $signed(r_k ? r_c10[31:16] : r_c00[31:16]);
        ai = $signed(r_k ? r_c10[15:0]  : r_c00[15:0]);
        br = $signed(r_k ? r_c11[31:16] : r_c01[31:16]);
        bi = $signed(r_k ? r_c11[15:0]  : r_c01[15:0]);
        xr = $signed(r_s0[31:16]);
        xi = $signed(r_s0[15:0]);
        yr = $signed(r_s1[31:16]);
        yi = $signed(r_s1[15:0]);
    end

    // Sums of products, squared magnitude and saturating accumulate.
    logic signed [33:0] sum_re, sum_im;
    logic [31:0]        sq;
    logic [40:0]        acc_sum;
    always_comb begin
        sum_re  = 34'(r_pr[0]) - 34'(r_pr[1]) + 34'(r_pr[2]) - 34'(r_pr[3]);
        sum_im  = 34'(r_pi[0]) + 34'(r_pi[1]) + 34'(r_pi[2]) + 34'(r_pi[3]);
        sq      = 32'($signed(r_re) * $signed(r_re)) + 32'($signed(r_im) * $signed(r_im));
        acc_sum = {1'b0, r_acc} + 41'(sq);
    end

    // RAM access per state.
    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_wj ? addr_j : addr_i;
        ram_wdata = r_wj ? r_a1 : r_a0;
        ram_raddr = addr_i;
        case (r_state)
            ST_IDLE: begin
                ram_waddr = in_addr;
                ram_raddr = in_addr;
                ram_wdata = {i_req.amp_re, i_req.amp_im};
                if (i_req.valid) begin
                    ram_we = i_req.func == svg_pkg::FUNC_WRITE;
                    ram_re = i_req.func == svg_pkg::FUNC_READ;
                end
            end
            ST_RDI: ram_re = 1'b1;
            ST_RDJ: begin
                ram_re    = 1'b1;
                ram_raddr = addr_j;
            end
            ST_WR:   ram_we = 1'b1;
            default: ;
        endcase
    end

    // Configuration writes.
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c00   <= svg_pkg::COEF_ONE;
            r_c01   <= svg_pkg::COEF_ZERO;
            r_c10   <= svg_pkg::COEF_ZERO;
            r_c11   <= svg_pkg::COEF_ONE;
            r_tq    <= '0;
            r_qiu   <= svg_pkg::QUBITS_RST;
            r_scale <= svg_pkg::SCALE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.idx)
                svg_pkg::REG_COEF_00: r_c00   <= i_cfg.data;
                svg_pkg::REG_COEF_01: r_c01   <= i_cfg.data;
                svg_pkg::REG_COEF_10: r_c10   <= i_cfg.data;
                svg_pkg::REG_COEF_11: r_c11   <= i_cfg.data;
                svg_pkg::REG_TARGET:  r_tq    <= i_cfg.data[3:0];
                svg_pkg::REG_QUBITS:  r_qiu   <= i_cfg.data[3:0];
                svg_pkg::REG_SCALE:   r_scale <= i_cfg.data[23:0];
                default: ;
            endcase
        end
    end

    assign i_req.ready = r_state == ST_IDLE;

    // Sequencer: probe and apply read a pair, run both outputs through the
    // multiply unit, then accumulate the norm or write the pair back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_func <= i_req.func;
                        r_err  <= 1'b0;
                        r_p    <= '0;
                        r_acc  <= '0;
                        r_wj   <= 1'b0;
                        case (i_req.func)
                            svg_pkg::FUNC_WRITE: r_state <= ST_DONE;
                            svg_pkg::FUNC_READ:  r_state <= ST_RDOUT;
                            default: begin
                                r_err   <= bad_tgt;
                                r_state <= bad_tgt ? ST_DONE : ST_RDI;
                            end
                        endcase
                    end
                end
                ST_RDOUT: begin
                    r_rd    <= ram_rdata;
                    r_state <= ST_DONE;
                end
                ST_RDI: r_state <= ST_RDJ;
                ST_RDJ: begin
                    r_s0    <= ram_rdata;
                    r_state <= ST_CAPJ;
                end
                ST_CAPJ: begin
                    r_s1    <= ram_rdata;
                    r_k     <= 1'b0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_pr[0] <= ar * xr;
                    r_pr[1] <= ai * xi;
                    r_pr[2] <= br * yr;
                    r_pr[3] <= bi * yi;
                    r_pi[0] <= ar * xi;
                    r_pi[1] <= ai * xr;
                    r_pi[2] <= br * yi;
                    r_pi[3] <= bi * yr;
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_re    <= svg_pkg::rnd14(sum_re);
                    r_im    <= svg_pkg::rnd14(sum_im);
                    r_state <= ST_POST;
                end
                ST_POST: begin
                    if (r_func == svg_pkg::FUNC_PROBE) begin
                        r_acc <= acc_sum > {1'b0, svg_pkg::NORM_MAX}
                                 ? svg_pkg::NORM_MAX : acc_sum[39:0];
                        if (!r_k) begin
                            r_k     <= 1'b1;
                            r_state <= ST_MUL;
                        end else if (last_pair) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_p     <= r_p + AW'(1);
                            r_state <= ST_RDI;
                        end
                    end else begin
                        r_sre   <= $signed(r_re) * $signed({1'b0, r_scale});
                        r_sim   <= $signed(r_im) * $signed({1'b0, r_scale});
                        r_state <= ST_SCL;
                    end
                end
                ST_SCL: begin
                    if (!r_k) begin
                        r_a0    <= {svg_pkg::rnd16(r_sre), svg_pkg::rnd16(r_sim)};
                        r_k     <= 1'b1;
                        r_state <= ST_MUL;
                    end else begin
                        r_a1    <= {svg_pkg::rnd16(r_sre), svg_pkg::rnd16(r_sim)};
                        r_wj    <= 1'b0;
                        r_state <= ST_WR;
                    end
                end
                ST_WR: begin
                    // Writes entry i, then entry j of the pair.
                    if (!r_wj) begin
                        r_wj <= 1'b1;
                    end else if (last_pair) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_p     <= r_p + AW'(1);
                        r_state <= ST_RDI;
                    end
                end
                ST_DONE: begin
                    if (!r_ov || o_rsp.ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Result register, loaded once the previous item has been taken.
    logic load_out;
    assign load_out = (r_state == ST_DONE) && (!r_ov || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load_out) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_ore   <= (r_func == svg_pkg::FUNC_READ) ? r_rd[31:16] : '0;
            r_oim   <= (r_func == svg_pkg::FUNC_READ) ? r_rd[15:0]  : '0;
            r_onorm <= (r_func == svg_pkg::FUNC_PROBE && !r_err) ? r_acc : '0;
            r_oerr  <= r_err;
        end
    end

    assign o_rsp.valid    = r_ov;
    assign o_rsp.out_re   = r_ore;
    assign o_rsp.out_im   = r_oim;
    assign o_rsp.norm_sum = r_onorm;
    assign o_rsp.error    = r_oerr;

endmodule

### sv/svg_chk.sv
// ----------------------------------------------------------------------------
// svg_chk
// Port-level checks of the gate engine, attached to the top level by bind.
// ----------------------------------------------------------------------------
module svg_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [15:0] i_out_re,
    input logic [15:0] i_out_im,
    input logic [39:0] i_norm_sum,
    input logic        i_error
);

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_out_re)
        && $stable(i_out_im) && $stable(i_norm_sum) && $stable(i_error))
        else $error("result changed while stalled");

    // An error result carries no amplitude and no norm.
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_error |-> i_out_re == 16'd0 && i_out_im == 16'd0
        && i_norm_sum == 40'd0)
        else $error("error result with payload");

    // Norm and read-back amplitude never appear together.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_norm_sum != 40'd0 |-> i_out_re == 16'd0 && i_out_im == 16'd0)
        else $error("norm and amplitude in one result");

    // Reset leaves no result pending.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

endmodule

bind state_vector_one_qubit_gate svg_chk u_svg_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_out_re    (o_rsp.out_re),
    .i_out_im    (o_rsp.out_im),
    .i_norm_sum  (o_rsp.norm_sum),
    .i_error     (o_rsp.error)
);

### bench/state_vector_one_qubit_gate_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// state_vector_one_qubit_gate_tb
// Drives load, read, probe and apply items into the gate engine while random
// register settings are written between phases. A scoreboard class keeps its
// own copy of the amplitude store and the registers, predicts each result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module state_vector_one_qubit_gate_tb;

    localparam int DEPTH = 1 << svg_pkg::MAX_QUBITS_DEF;
    localparam int CYCLE_LIMIT = 4000000;

    // One expected result.
    typedef struct packed {
        logic [svg_pkg::AMP_W-1:0]  re;
        logic [svg_pkg::AMP_W-1:0]  im;
        logic [svg_pkg::NORM_W-1:0] norm;
        logic                       err;
    } t_result;

    // Predicts the gate engine and checks its results in order.
    class gate_scoreboard;
        logic [svg_pkg::WORD_W-1:0]  amps [DEPTH];
        logic [svg_pkg::WORD_W-1:0]  coef [4];
        int unsigned                 target;
        int unsigned                 qubits;
        logic [svg_pkg::SCALE_W-1:0] scale;
        t_result                     pending [$];
        int                          mismatches;

        function void init();
            coef[0] = svg_pkg::COEF_ONE;
            coef[1] = svg_pkg::COEF_ZERO;
            coef[2] = svg_pkg::COEF_ZERO;
            coef[3] = svg_pkg::COEF_ONE;
            target = 0;
            qubits = svg_pkg::QUBITS_RST;
            scale = svg_pkg::SCALE_RST;
            mismatches = 0;
            foreach (amps[k]) amps[k] = '0;
        endfunction

        function void set_reg(logic [svg_pkg::CFG_IDX_W-1:0] idx,
                              logic [svg_pkg::CFG_DAT_W-1:0] val);
            case (idx)
                svg_pkg::REG_COEF_00: coef[0] = val;
                svg_pkg::REG_COEF_01: coef[1] = val;
                svg_pkg::REG_COEF_10: coef[2] = val;
                svg_pkg::REG_COEF_11: coef[3] = val;
                svg_pkg::REG_TARGET:  target = val[3:0];
                svg_pkg::REG_QUBITS:  qubits = val[3:0];
                svg_pkg::REG_SCALE:   scale = val[svg_pkg::SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        // Add half, floor-shift by k and clamp to a signed 16-bit part.
        function longint round_clamp(longint x, int k);
            longint q;
            q = (x + (longint'(1) << (k - 1))) >>> k;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            return q;
        endfunction

        function longint part(logic [svg_pkg::WORD_W-1:0] w, bit hi);
            return hi ? longint'($signed(w[31:16])) : longint'($signed(w[15:0]));
        endfunction

        // ca*sa + cb*sb, rounded to Q1.14.
        function void mix(logic [svg_pkg::WORD_W-1:0] ca, logic [svg_pkg::WORD_W-1:0] sa,
                          logic [svg_pkg::WORD_W-1:0] cb, logic [svg_pkg::WORD_W-1:0] sb,
                          output longint re, output longint im);
            re = round_clamp(part(ca,1)*part(sa,1) - part(ca,0)*part(sa,0)
                           + part(cb,1)*part(sb,1) - part(cb,0)*part(sb,0), 14);
            im = round_clamp(part(ca,1)*part(sa,0) + part(ca,0)*part(sa,1)
                           + part(cb,1)*part(sb,0) + part(cb,0)*part(sb,1), 14);
        endfunction

        function logic [15:0] rescale(longint v);
            return 16'(round_clamp(v * longint'(scale), 16));
        endfunction

        // Notes an accepted request and queues its result.
        function void note_request(svg_pkg::t_func func, logic [svg_pkg::INDEX_W-1:0] index,
                                   logic [svg_pkg::AMP_W-1:0] are,
                                   logic [svg_pkg::AMP_W-1:0] aim);
            t_result r;
            int unsigned n, stride, i, j;
            longint r0, m0, r1, m1, acc;
            r = '0;
            n = (qubits > svg_pkg::MAX_QUBITS_DEF) ? svg_pkg::MAX_QUBITS_DEF : qubits;
            if (func == svg_pkg::FUNC_WRITE) begin
                amps[index] = {are, aim};
            end else if (func == svg_pkg::FUNC_READ) begin
                r.re = amps[index][31:16];
                r.im = amps[index][15:0];
            end else if (target >= n) begin
                r.err = 1'b1;
            end else begin
                stride = 1 << target;
                acc = 0;
                for (int unsigned p = 0; p < ((1 << n) >> 1); p++) begin
                    i = (p & (stride - 1)) | ((p & ~(stride - 1)) << 1);
                    j = i | stride;
                    mix(coef[0], amps[i], coef[1], amps[j], r0, m0);
                    mix(coef[2], amps[i], coef[3], amps[j], r1, m1);
                    if (func == svg_pkg::FUNC_PROBE) begin
                        acc += r0*r0 + m0*m0;
                        if (acc > longint'(svg_pkg::NORM_MAX)) acc = svg_pkg::NORM_MAX;
                        acc += r1*r1 + m1*m1;
                        if (acc > longint'(svg_pkg::NORM_MAX)) acc = svg_pkg::NORM_MAX;
                    end else begin
                        amps[i] = {rescale(r0), rescale(m0)};
                        amps[j] = {rescale(r1), rescale(m1)};
                    end
                end
                if (func == svg_pkg::FUNC_PROBE) r.norm = acc[svg_pkg::NORM_W-1:0];
            end
            pending.push_back(r);
        endfunction

        // Compares one returned result with the oldest expectation.
        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (got.re !== want.re)
                $display("%0t: out_re expected %h actual %h", $time, want.re, got.re);
            if (got.im !== want.im)
                $display("%0t: out_im expected %h actual %h", $time, want.im, got.im);
            if (got.norm !== want.norm)
                $display("%0t: norm_sum expected %h actual %h", $time, want.norm, got.norm);
            if (got.err !== want.err)
                $display("%0t: error expected %b actual %b", $time, want.err, got.err);
            if (got !== want) mismatches++;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    svg_req_if req_ch ();
    svg_rsp_if rsp_ch ();
    svg_cfg_if cfg_ch ();

    gate_scoreboard board;
    int  cycles;
    bit  long_hold;

    state_vector_one_qubit_gate uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    // Clock and cycle limit.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Sends one request and notes it once it is accepted. Valid stays high
    // after acceptance so that a following item can go out back to back;
    // the next call replaces or drops it, and a register write or a drain drops it.
    task automatic send_request(svg_pkg::t_func func, logic [svg_pkg::INDEX_W-1:0] index,
                                logic [svg_pkg::AMP_W-1:0] are,
                                logic [svg_pkg::AMP_W-1:0] aim);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        cfg_ch.valid <= 1'b0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.func   <= func;
        req_ch.index  <= index;
        req_ch.amp_re <= are;
        req_ch.amp_im <= aim;
        do @(posedge i_clk); while (!req_ch.ready);
        board.note_request(func, index, are, aim);
    endtask

    // Writes one register; valid is dropped by the next request or a drain.
    task automatic write_reg(logic [svg_pkg::CFG_IDX_W-1:0] idx,
                             logic [svg_pkg::CFG_DAT_W-1:0] val);
        req_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b1;
        cfg_ch.idx   <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        board.set_reg(idx, val);
    endtask

    // Waits until every result is back, then lets a bad-target pass settle.
    task automatic drain();
        req_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic load_amp(int unsigned k, logic [svg_pkg::AMP_W-1:0] re,
                            logic [svg_pkg::AMP_W-1:0] im);
        send_request(svg_pkg::FUNC_WRITE, k[svg_pkg::INDEX_W-1:0], re, im);
    endtask

    // Random small amplitude; mostly moderate values, some full scale.
    function automatic logic [svg_pkg::AMP_W-1:0] rand_part();
        if ($urandom_range(0, 4) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 16384)) - 8192);
    endfunction

    // Random operator entry with the same mix.
    function automatic logic [svg_pkg::WORD_W-1:0] rand_coef();
        return {rand_part(), rand_part()};
    endfunction

    // Result side: random stalls and one long hold-off.
    initial begin
        t_result got;
        rsp_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                rsp_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                long_hold = 1'b0;
            end
            if ($urandom_range(0, 2) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.re   = rsp_ch.out_re;
                got.im   = rsp_ch.out_im;
                got.norm = rsp_ch.norm_sum;
                got.err  = rsp_ch.error;
                board.check_result(got);
            end
        end
    end

    // Stimulus.
    initial begin
        int unsigned n, k;
        board = new();
        board.init();
        long_hold = 1'b0;
        i_rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.func <= svg_pkg::FUNC_WRITE;
        req_ch.index <= '0;
        req_ch.amp_re <= '0;
        req_ch.amp_im <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.idx <= svg_pkg::REG_COEF_00;
        cfg_ch.data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: small state, extremes of fields, every function.
        write_reg(svg_pkg::REG_QUBITS, 2);
        load_amp(0, 16'h7FFF, 16'h8000);
        load_amp(1, 16'h8000, 16'h7FFF);
        load_amp(2, 16'h4000, 16'h0000);
        load_amp(3, 16'hFFFF, 16'h0001);
        load_amp(DEPTH - 1, 16'h5555, 16'hAAAA);
        send_request(svg_pkg::FUNC_READ, 0, 16'hFFFF, 16'hFFFF);
        send_request(svg_pkg::FUNC_READ, 10'h3FF, 0, 0);
        send_request(svg_pkg::FUNC_PROBE, 10'h3FF, 0, 0);
        send_request(svg_pkg::FUNC_APPLY, 0, 0, 0);
        send_request(svg_pkg::FUNC_READ, 1, 0, 0);
        drain();
        // Saturating operator and bad target.
        write_reg(svg_pkg::REG_COEF_00, 32'h8000_8000);
        write_reg(svg_pkg::REG_COEF_01, 32'h7FFF_7FFF);
        write_reg(svg_pkg::REG_COEF_10, 32'h7FFF_8000);
        write_reg(svg_pkg::REG_COEF_11, 32'h8000_7FFF);
        write_reg(svg_pkg::REG_SCALE, 24'hFFFFFF);
        write_reg(svg_pkg::REG_TARGET, 1);
        send_request(svg_pkg::FUNC_PROBE, 0, 0, 0);
        send_request(svg_pkg::FUNC_APPLY, 0, 0, 0);
        send_request(svg_pkg::FUNC_READ, 2, 0, 0);
        drain();
        write_reg(svg_pkg::REG_SCALE, 0);
        write_reg(svg_pkg::REG_TARGET, 2);
        send_request(svg_pkg::FUNC_PROBE, 0, 0, 0);
        send_request(svg_pkg::FUNC_APPLY, 0, 0, 0);
        drain();
        write_reg(svg_pkg::REG_QUBITS, 0);
        write_reg(svg_pkg::REG_TARGET, 0);
        send_request(svg_pkg::FUNC_PROBE, 0, 0, 0);
        send_request(svg_pkg::FUNC_APPLY, 0, 0, 0);
        drain();
        // Count above the store size saturates; fill the whole store first.
        write_reg(svg_pkg::REG_QUBITS, 15);
        write_reg(svg_pkg::REG_TARGET, 9);
        write_reg(svg_pkg::REG_SCALE, svg_pkg::SCALE_RST);
        for (k = 0; k < DEPTH; k++) load_amp(k, rand_part(), rand_part());
        send_request(svg_pkg::FUNC_PROBE, 0, 0, 0);
        send_request(svg_pkg::FUNC_APPLY, 0, 0, 0);
        send_request(svg_pkg::FUNC_READ, 10'h200, 0, 0);
        drain();

        // Long result stall while requests keep coming.
        write_reg(svg_pkg::REG_QUBITS, 1);
        long_hold = 1'b1;
        for (k = 0; k < 20; k++) send_request(svg_pkg::FUNC_READ, 10'($urandom), 0, 0);
        drain();

        // Random phases: new settings, then load, read, probe and apply.
        repeat (4) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
            write_reg(svg_pkg::REG_COEF_00, rand_coef());
            write_reg(svg_pkg::REG_COEF_01, rand_coef());
            write_reg(svg_pkg::REG_COEF_10, rand_coef());
            write_reg(svg_pkg::REG_COEF_11, rand_coef());
            write_reg(svg_pkg::REG_TARGET, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                                       : $urandom_range(0, 3));
            write_reg(svg_pkg::REG_QUBITS, n);
            write_reg(svg_pkg::REG_SCALE, ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                                      : $urandom_range(40000, 90000));
            repeat (29) begin
                k = $urandom_range(0, 9);
                if (k < 3) load_amp($urandom_range(0, DEPTH - 1), rand_part(), rand_part());
                else if (k < 6) send_request(svg_pkg::FUNC_READ, 10'($urandom), 0, 0);
                else if (k < 8) send_request(svg_pkg::FUNC_PROBE, 10'($urandom),
                                             16'($urandom), 16'($urandom));
                else send_request(svg_pkg::FUNC_APPLY, 10'($urandom), 16'($urandom),
                                  16'($urandom));
            end
            drain();
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
